[rtl/alep_pkg.sv]
// Shared types and constants for the associated Legendre evaluator.
`timescale 1ns / 1ps
package alep_pkg;
   localparam int ARG_W = 18;
   localparam int CFG_W = 4;
   localparam int OUT_W = 48;
   localparam int VAL_W = 64;
   localparam int CNT_W = 6;
   localparam int IDX_W = 1;

   // intermediate magnitude limit and output range
   localparam logic [VAL_W-1:0] INT_LIM = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] OUT_MIN = -64'sh0000_8000_0000_0000;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_DEGREE = 1'b0;
   localparam logic [IDX_W-1:0] REG_ORDER  = 1'b1;

   // which product the shared unit is working on
   typedef enum logic [1:0] {
      PH_PMM,
      PH_Q0,
      PH_A,
      PH_B
   } phase_type;
endpackage

[rtl/associated_legendre_eval_unit.sv]
// Associated Legendre function evaluator, P_l^m(x), fixed point.
// When order exceeds the degree (clamped to L_MAX) the result is zero; else
//   a square root (only when m > 0) and a product chain give P_m^m, and when l > m
//   a recurrence up to degree l follows; built on the shared 32x32 multiplier and the divider.
// Throughput: one request at a time, the next is taken once the result sits in
//   the output register. Sync reset clears control, rsp_valid and both config regs.
`timescale 1ns / 1ps
module associated_legendre_eval_unit import alep_pkg::*; #(
   parameter int L_MAX     = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]        csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [ARG_W-1:0] req_arg,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_value,
   output logic                    rsp_saturated
);
   localparam int XW = 33;
   localparam int SH = 32 - FRAC_BITS;
   localparam logic signed [XW-1:0] ONE = XW'(1) <<< FRAC_BITS;
   localparam logic [VAL_W-1:0] PH_LIM = INT_LIM >> SH;

   typedef enum logic [3:0] {
      S_IDLE, S_RAD, S_SQRT, S_MQ_SET, S_MQ_LO, S_MQ_HI, S_MQ_FIN,
      S_MK, S_POST, S_SUB, S_DIV, S_FIN
   } state_type;

   state_type state_ff;
   phase_type phase_ff;

   logic [CFG_W-1:0] degree_ff, order_ff;
   logic [CNT_W-1:0] l_ff, m_ff, i_ff, k_ff, mk_k_ff;
   logic signed [XW-1:0] x_ff;
   logic [31:0] s_ff;
   logic signed [VAL_W-1:0] p_ff, q_ff, a_ff, b_ff, mk_op_ff, result_ff;
   logic sat_ff;

   // square root
   logic [VAL_W-1:0] rt_v_ff, rt_res_ff, rt_bit_ff;
   // fixed-point product
   logic [VAL_W-1:0] ua_ff, pl_ff, ph_ff;
   logic [31:0] ub_ff;
   logic neg_ff;
   // divider
   logic [VAL_W-1:0] dv_num_ff, dv_quo_ff;
   logic [4:0] dv_rem_ff;
   logic [3:0] dv_cnt_ff;
   logic dv_neg_ff;

   logic rsp_valid_ff, rsp_sat_ff;
   logic signed [OUT_W-1:0] rsp_value_ff;

   // ---------------- request decode ----------------
   logic signed [XW-1:0] arg_ext, arg_clamped;
   logic [CNT_W-1:0] l_req, m_req;
   always_comb begin
      arg_ext = XW'(req_arg);
      arg_clamped = arg_ext;
      if (arg_ext > ONE) arg_clamped = ONE;
      if (arg_ext < -ONE) arg_clamped = -ONE;
      l_req = CNT_W'(degree_ff);
      if (l_req > CNT_W'(L_MAX)) l_req = CNT_W'(L_MAX);
      m_req = CNT_W'(order_ff);
   end

   // ---------------- shared 32x32 multiplier ----------------
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic signed [XW-1:0] one_minus_x, one_plus_x;
   always_comb begin
      one_minus_x = ONE - x_ff;
      one_plus_x  = ONE + x_ff;
      case (state_ff)
         S_RAD: begin
            mul_a = one_minus_x[31:0];
            mul_b = one_plus_x[31:0];
         end
         S_MQ_HI: begin
            mul_a = ua_ff[63:32];
            mul_b = ub_ff;
         end
         default: begin
            mul_a = ua_ff[31:0];
            mul_b = ub_ff;
         end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   // ---------------- square root step ----------------
   logic [VAL_W-1:0] rt_trial;
   assign rt_trial = rt_res_ff + rt_bit_ff;

   // ---------------- product operands ----------------
   logic signed [VAL_W-1:0] mq_a;
   logic signed [XW-1:0] mq_b;
   always_comb begin
      mq_a = (phase_ff == PH_A) ? q_ff : p_ff;
      mq_b = (phase_ff == PH_PMM) ? XW'({1'b0, s_ff}) : x_ff;
   end

   // truncate Q.2F product back to Q.F, clip to the intermediate limit
   logic [VAL_W:0] mq_sum;
   logic mq_over;
   logic signed [VAL_W-1:0] mq_res;
   always_comb begin
      mq_sum  = {1'b0, ph_ff << SH} + (VAL_W+1)'(pl_ff >> FRAC_BITS);
      mq_over = (ph_ff > PH_LIM) || (mq_sum > (VAL_W+1)'(INT_LIM));
      mq_res  = mq_over ? INT_LIM : mq_sum[VAL_W-1:0];
      if (neg_ff) mq_res = -mq_res;
   end

   // ---------------- small-integer product ----------------
   logic [VAL_W-1:0] mk_mag;
   logic [VAL_W+CNT_W-1:0] mk_prod;
   logic mk_over;
   logic signed [VAL_W-1:0] mk_res;
   always_comb begin
      mk_mag  = mk_op_ff[VAL_W-1] ? VAL_W'(-mk_op_ff) : mk_op_ff;
      mk_prod = (VAL_W+CNT_W)'(mk_mag) * (VAL_W+CNT_W)'(mk_k_ff);
      mk_over = mk_prod > (VAL_W+CNT_W)'(INT_LIM);
      if (mk_over) mk_res = INT_LIM;
      else mk_res = mk_prod[VAL_W-1:0];
      if (mk_op_ff[VAL_W-1]) mk_res = -mk_res;
   end

   // ---------------- difference and clip ----------------
   logic signed [VAL_W:0] diff;
   logic signed [VAL_W-1:0] diff_clip;
   logic diff_over;
   always_comb begin
      diff = (VAL_W+1)'(a_ff) - (VAL_W+1)'(b_ff);
      diff_over = 1'b0;
      diff_clip = diff[VAL_W-1:0];
      if (diff > $signed({1'b0, INT_LIM})) begin
         diff_clip = INT_LIM;
         diff_over = 1'b1;
      end
      if (diff < -$signed({1'b0, INT_LIM})) begin
         diff_clip = -INT_LIM;
         diff_over = 1'b1;
      end
   end

   // ---------------- divider: four quotient bits a cycle ----------------
   logic [CNT_W-1:0] den;
   logic [6:0] dv_r;
   logic [3:0] dv_digit;
   logic [VAL_W-1:0] dv_quo_next;
   logic signed [VAL_W-1:0] dv_result;
   always_comb begin
      den = k_ff - m_ff;
      dv_r = 7'(dv_rem_ff);
      dv_digit = '0;
      for (int j = 0; j < 4; j++) begin
         dv_r = {dv_r[5:0], dv_num_ff[VAL_W-1-j]};
         if (dv_r >= 7'(den)) begin
            dv_r = dv_r - 7'(den);
            dv_digit[3-j] = 1'b1;
         end
      end
      dv_quo_next = {dv_quo_ff[VAL_W-5:0], dv_digit};
      dv_result = dv_neg_ff ? -dv_quo_next : dv_quo_next;
   end

   // ---------------- output clip ----------------
   logic signed [OUT_W-1:0] out_value;
   logic out_over;
   always_comb begin
      out_over = 1'b0;
      out_value = result_ff[OUT_W-1:0];
      if (result_ff > OUT_MAX) begin
         out_value = OUT_MAX[OUT_W-1:0];
         out_over = 1'b1;
      end
      if (result_ff < OUT_MIN) begin
         out_value = OUT_MIN[OUT_W-1:0];
         out_over = 1'b1;
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_PMM;
         degree_ff    <= '0;
         order_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
      end else begin
         // configuration writes land at once
         if (csr_write_en) begin
            case (csr_index)
               REG_DEGREE: degree_ff <= csr_wdata;
               REG_ORDER:  order_ff  <= csr_wdata;
               default: ;
            endcase
         end

         // drop the response once taken; the final state reloads it itself
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FIN)) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x_ff   <= arg_clamped;
                  l_ff   <= l_req;
                  m_ff   <= m_req;
                  sat_ff <= 1'b0;
                  p_ff   <= VAL_W'(ONE);
                  if (m_req > l_req) begin
                     result_ff <= '0;
                     state_ff  <= S_FIN;
                  end else if (m_req == '0) begin
                     state_ff <= S_POST;
                  end else begin
                     state_ff <= S_RAD;
                  end
               end
            end
            S_RAD: begin
               rt_v_ff   <= mul_p;
               rt_res_ff <= '0;
               rt_bit_ff <= VAL_W'(1) << (VAL_W - 2);
               state_ff  <= S_SQRT;
            end
            S_SQRT: begin
               if (rt_v_ff >= rt_trial) begin
                  rt_v_ff   <= rt_v_ff - rt_trial;
                  rt_res_ff <= (rt_res_ff >> 1) + rt_bit_ff;
               end else begin
                  rt_res_ff <= rt_res_ff >> 1;
               end
               rt_bit_ff <= rt_bit_ff >> 2;
               if (rt_bit_ff == VAL_W'(1)) begin
                  s_ff <= (rt_v_ff >= rt_trial) ?
                          32'((rt_res_ff >> 1) + rt_bit_ff) : 32'(rt_res_ff >> 1);
                  i_ff     <= CNT_W'(1);
                  phase_ff <= PH_PMM;
                  state_ff <= S_MQ_SET;
               end
            end
            S_MQ_SET: begin
               neg_ff   <= (mq_a < 0) != (mq_b < 0);
               ua_ff    <= mq_a[VAL_W-1] ? VAL_W'(-mq_a) : mq_a;
               ub_ff    <= mq_b[XW-1] ? 32'(-mq_b) : 32'(mq_b);
               state_ff <= S_MQ_LO;
            end
            S_MQ_LO: begin
               pl_ff    <= mul_p;
               state_ff <= S_MQ_HI;
            end
            S_MQ_HI: begin
               ph_ff    <= mul_p;
               state_ff <= S_MQ_FIN;
            end
            S_MQ_FIN: begin
               if (mq_over) sat_ff <= 1'b1;
               mk_op_ff <= mq_res;
               case (phase_ff)
                  PH_PMM:  mk_k_ff <= CNT_W'((i_ff << 1) - CNT_W'(1));
                  PH_Q0:   mk_k_ff <= CNT_W'((m_ff << 1) + CNT_W'(1));
                  default: mk_k_ff <= CNT_W'((k_ff << 1) - CNT_W'(1));
               endcase
               state_ff <= S_MK;
            end
            S_MK: begin
               if (mk_over) sat_ff <= 1'b1;
               case (phase_ff)
                  PH_PMM: begin
                     p_ff <= -mk_res;
                     if (i_ff == m_ff) begin
                        state_ff <= S_POST;
                     end else begin
                        i_ff     <= i_ff + CNT_W'(1);
                        state_ff <= S_MQ_SET;
                     end
                  end
                  PH_Q0: begin
                     q_ff <= mk_res;
                     k_ff <= m_ff + CNT_W'(2);
                     if (m_ff + CNT_W'(2) > l_ff) begin
                        result_ff <= mk_res;
                        state_ff  <= S_FIN;
                     end else begin
                        phase_ff <= PH_A;
                        state_ff <= S_MQ_SET;
                     end
                  end
                  PH_A: begin
                     a_ff     <= mk_res;
                     mk_op_ff <= p_ff;
                     mk_k_ff  <= k_ff + m_ff - CNT_W'(1);
                     phase_ff <= PH_B;
                  end
                  default: begin
                     b_ff     <= mk_res;
                     state_ff <= S_SUB;
                  end
               endcase
            end
            S_POST: begin
               if (l_ff == m_ff) begin
                  result_ff <= p_ff;
                  state_ff  <= S_FIN;
               end else begin
                  phase_ff <= PH_Q0;
                  state_ff <= S_MQ_SET;
               end
            end
            S_SUB: begin
               if (diff_over) sat_ff <= 1'b1;
               dv_neg_ff <= diff_clip[VAL_W-1];
               dv_num_ff <= diff_clip[VAL_W-1] ? VAL_W'(-diff_clip) : diff_clip;
               dv_quo_ff <= '0;
               dv_rem_ff <= '0;
               dv_cnt_ff <= '0;
               state_ff  <= S_DIV;
            end
            S_DIV: begin
               dv_num_ff <= dv_num_ff << 4;
               dv_quo_ff <= dv_quo_next;
               dv_rem_ff <= dv_r[4:0];
               dv_cnt_ff <= dv_cnt_ff + 4'd1;
               if (dv_cnt_ff == 4'hF) begin
                  p_ff <= q_ff;
                  q_ff <= dv_result;
                  k_ff <= k_ff + CNT_W'(1);
                  if (k_ff + CNT_W'(1) > l_ff) begin
                     result_ff <= dv_result;
                     state_ff  <= S_FIN;
                  end else begin
                     phase_ff <= PH_A;
                     state_ff <= S_MQ_SET;
                  end
               end
            end
            S_FIN: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= out_value;
                  rsp_sat_ff   <= sat_ff | out_over;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_saturated = rsp_sat_ff;
endmodule

[rtl/alep_checker.sv]
// Port-level checks for the associated Legendre evaluator.
`timescale 1ns / 1ps
module alep_checker import alep_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_value,
   input logic                    rsp_saturated
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_saturated))
      else $error("response changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response too early");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind associated_legendre_eval_unit alep_checker u_alep_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_value(rsp_value),
   .rsp_saturated(rsp_saturated)
);
